>>> rtl/cle_pkg.sv
package cle_pkg;

  localparam int VAL_W   = 32;
  localparam int SUM_W   = 37;
  localparam int COUNT_W = 6;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT   = 3'd0,
    ACT_INSERT_AFTER = 3'd1,
    ACT_PUSH_BACK    = 3'd2,
    ACT_POP_FRONT    = 3'd3,
    ACT_REMOVE_MATCH = 3'd4,
    ACT_POP_BACK     = 3'd5,
    ACT_FIND         = 3'd6,
    ACT_DUMP         = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

>>> rtl/circular_list_engine.sv
// Circular singly linked list of signed 32-bit values held in a CAPACITY-node
// store. An item is taken when start is high and busy is low; results come back
// on strobe, one cycle each, and cannot be held off. Count and sum on the result
// ports are the values after the action. A push writes the node in S_PUSH and,
// when the list is not empty, links it in S_PUSH_LINK; an item turned away on
// entry (empty list, or a push to a full list) is answered from S_IDLE.
// Find, remove-match, insert-after and pop back walk the list one node per cycle
// through the single read port of the node store: a load step (S_LOAD), then
// S_WALK visits each node up to the match (or up to the tail, or all count nodes
// when nothing matches), then the link update in S_ACT and, for insert-after,
// S_LINK. Pop front matches at the first node. A dump gives one result per cycle
// after the load step. No clearing pass is needed after reset.
module circular_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          action,
  input  logic signed [cle_pkg::VAL_W-1:0]    match_value,
  input  logic signed [cle_pkg::VAL_W-1:0]    new_value,
  output logic                                strobe,
  output logic [1:0]                          status,
  output logic signed [cle_pkg::VAL_W-1:0]    item,
  output logic [cle_pkg::COUNT_W-1:0]         count_now,
  output logic signed [cle_pkg::SUM_W-1:0]    sum_now,
  output logic                                last_of_run
);
  import cle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EXT_W = SUM_W - VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_LINK,
    S_LOAD,
    S_WALK,
    S_ACT,
    S_LINK
  } state_t;

  // node store
  logic [VAL_W-1:0] node_values [CAPACITY];
  logic [IW-1:0]    node_links  [CAPACITY];
  logic [VAL_W-1:0] rd_val;
  logic [IW-1:0]    rd_link;
  logic [IW-1:0]    raddr;
  logic             val_we, link_we;
  logic [IW-1:0]    val_wa, link_wa;
  logic [VAL_W-1:0] val_wd;
  logic [IW-1:0]    link_wd;

  // control and list registers
  state_t              state, state_next;
  action_t             op, op_next;
  logic [VAL_W-1:0]    mv, mv_next;
  logic [VAL_W-1:0]    nv, nv_next;
  logic [IW-1:0]       first, first_next;
  logic [IW-1:0]       last, last_next;
  logic [CW-1:0]       count, count_next;
  logic [SUM_W-1:0]    sum, sum_next;
  logic [CAPACITY-1:0] slot_free, slot_free_next;
  logic [IW-1:0]       cur, cur_next;
  logic [IW-1:0]       prev, prev_next;
  logic [IW-1:0]       tgt, tgt_next;
  logic [IW-1:0]       new_slot, new_slot_next;
  logic [CW-1:0]       n, n_next;

  // result registers
  logic             strobe_next;
  status_t          out_status, out_status_next;
  logic [VAL_W-1:0] out_item, out_item_next;
  logic             out_last, out_last_next;

  logic          full, empty, hit, at_end;
  logic [IW-1:0] free_idx;
  action_t       act_in;

  assign act_in = action_t'(action);
  assign full   = count >= CW'(CAPACITY);
  assign empty  = count == '0;
  assign at_end = (n + CW'(1)) >= count;
  assign hit    = (op == ACT_POP_FRONT || op == ACT_POP_BACK) ? (cur == tgt)
                                                              : (rd_val == mv);

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slot_free[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    mv_next         = mv;
    nv_next         = nv;
    first_next      = first;
    last_next       = last;
    count_next      = count;
    sum_next        = sum;
    slot_free_next  = slot_free;
    cur_next        = cur;
    prev_next       = prev;
    tgt_next        = tgt;
    new_slot_next   = new_slot;
    n_next          = n;
    strobe_next     = 1'b0;
    out_status_next = out_status;
    out_item_next   = out_item;
    out_last_next   = out_last;
    raddr           = cur;
    val_we          = 1'b0;
    val_wa          = new_slot;
    val_wd          = nv;
    link_we         = 1'b0;
    link_wa         = new_slot;
    link_wd         = new_slot;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next       = act_in;
          mv_next       = match_value;
          nv_next       = new_value;
          new_slot_next = free_idx;
          tgt_next      = (act_in == ACT_POP_FRONT) ? first : last;
          out_item_next = '0;
          out_last_next = 1'b1;
          if (act_in == ACT_PUSH_FRONT || act_in == ACT_PUSH_BACK) begin
            if (full) begin
              strobe_next     = 1'b1;
              out_status_next = ST_FULL;
            end else begin
              state_next = S_PUSH;
            end
          end else if (empty) begin
            strobe_next     = 1'b1;
            out_status_next = ST_EMPTY;
          end else begin
            state_next = S_LOAD;
          end
        end
      end

      S_PUSH: begin
        val_we  = 1'b1;
        link_we = 1'b1;
        link_wd = empty ? new_slot : first;
        slot_free_next[new_slot] = 1'b0;
        count_next = count + CW'(1);
        sum_next   = sum + {{EXT_W{nv[VAL_W-1]}}, nv};
        if (empty) begin
          first_next      = new_slot;
          last_next       = new_slot;
          strobe_next     = 1'b1;
          out_status_next = ST_DONE;
          state_next      = S_IDLE;
        end else begin
          state_next = S_PUSH_LINK;
        end
      end

      S_PUSH_LINK: begin
        link_we = 1'b1;
        link_wa = last;
        if (op == ACT_PUSH_FRONT) first_next = new_slot;
        else last_next = new_slot;
        strobe_next     = 1'b1;
        out_status_next = ST_DONE;
        state_next      = S_IDLE;
      end

      S_LOAD: begin
        raddr      = first;
        cur_next   = first;
        prev_next  = last;
        n_next     = '0;
        state_next = S_WALK;
      end

      S_WALK: begin
        if (op == ACT_DUMP) begin
          strobe_next     = 1'b1;
          out_status_next = ST_DONE;
          out_item_next   = rd_val;
          out_last_next   = at_end;
          if (at_end) begin
            state_next = S_IDLE;
          end else begin
            raddr     = rd_link;
            prev_next = cur;
            cur_next  = rd_link;
            n_next    = n + CW'(1);
          end
        end else if (hit) begin
          state_next = S_ACT;
        end else if (at_end) begin
          strobe_next     = 1'b1;
          out_status_next = ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          raddr     = rd_link;
          prev_next = cur;
          cur_next  = rd_link;
          n_next    = n + CW'(1);
        end
      end

      S_ACT: begin
        priority if (op == ACT_FIND) begin
          strobe_next     = 1'b1;
          out_status_next = ST_DONE;
          out_item_next   = rd_val;
          state_next      = S_IDLE;
        end else if (op == ACT_INSERT_AFTER) begin
          if (full) begin
            strobe_next     = 1'b1;
            out_status_next = ST_FULL;
            state_next      = S_IDLE;
          end else begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wd = rd_link;
            slot_free_next[new_slot] = 1'b0;
            count_next = count + CW'(1);
            sum_next   = sum + {{EXT_W{nv[VAL_W-1]}}, nv};
            state_next = S_LINK;
          end
        end else begin
          // removal of the node at cur, predecessor at prev
          if (count <= CW'(1)) begin
            first_next = '0;
            last_next  = '0;
          end else begin
            link_we = 1'b1;
            link_wa = prev;
            link_wd = rd_link;
            if (cur == first) first_next = rd_link;
            if (cur == last) last_next = prev;
          end
          slot_free_next[cur] = 1'b1;
          count_next      = count - CW'(1);
          sum_next        = sum - {{EXT_W{rd_val[VAL_W-1]}}, rd_val};
          strobe_next     = 1'b1;
          out_status_next = ST_DONE;
          out_item_next   = rd_val;
          state_next      = S_IDLE;
        end
      end

      S_LINK: begin
        link_we = 1'b1;
        link_wa = cur;
        if (cur == last) last_next = new_slot;
        strobe_next     = 1'b1;
        out_status_next = ST_DONE;
        state_next      = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) node_values[val_wa] <= val_wd;
    rd_val <= node_values[raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) node_links[link_wa] <= link_wd;
    rd_link <= node_links[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= '0;
      last      <= '0;
      count     <= '0;
      sum       <= '0;
      slot_free <= '1;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      first     <= first_next;
      last      <= last_next;
      count     <= count_next;
      sum       <= sum_next;
      slot_free <= slot_free_next;
      strobe    <= strobe_next;
    end
    op         <= op_next;
    mv         <= mv_next;
    nv         <= nv_next;
    cur        <= cur_next;
    prev       <= prev_next;
    tgt        <= tgt_next;
    new_slot   <= new_slot_next;
    n          <= n_next;
    out_status <= out_status_next;
    out_item   <= out_item_next;
    out_last   <= out_last_next;
  end

  assign busy        = state != S_IDLE;
  assign status      = out_status;
  assign item        = out_item;
  assign count_now   = COUNT_W'(count);
  assign sum_now     = sum;
  assign last_of_run = out_last;

endmodule
